>>> rtl/core/kvi_pkg.sv
`default_nettype none
package kvi_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int STEP_W    = 4;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int ACC_W     = FRAC_BITS + DIFF_W;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BEFORE   = 2'd1,
    ST_AFTER    = 2'd2,
    ST_ZERO_LEN = 2'd3
  } kvi_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_SCAN,
    S_INTERP,
    S_DONE
  } kvi_state_t;

  typedef struct packed {
    logic [DATA_W-1:0] tick;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
  } kvi_key_t;

  typedef struct packed {
    logic              opcode;
    logic [IDX_W-1:0]  key_index;
    logic [DATA_W-1:0] sample_time;
    logic [DATA_W-1:0] in_x;
    logic [DATA_W-1:0] in_y;
    logic [DATA_W-1:0] in_z;
  } kvi_in_beat_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_x;
    logic [DATA_W-1:0] out_y;
    logic [DATA_W-1:0] out_z;
    logic [IDX_W-1:0]  segment;
    kvi_status_t       status;
  } kvi_out_beat_t;

endpackage
`default_nettype wire

>>> rtl/core/kvi_if.sv
`default_nettype none
interface kvi_in_if;
  logic                 valid;
  logic                 ready;
  kvi_pkg::kvi_in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kvi_out_if;
  logic                  valid;
  logic                  ready;
  kvi_pkg::kvi_out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/keyframe_vector_interpolator.sv
// write beat: taken only while the sequencer is idle, and while idle a write can follow every cycle
// sample beat: key 0 is read first, then the keys after it are scanned in order (up to count-1),
//   then 16 shared divide/multiply steps, then the output is loaded
// one sample in flight at a time
// reset clears the sequencer and output valid and sets key_count to 1;
//   the key table is not cleared
`default_nettype none
module keyframe_vector_interpolator (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [kvi_pkg::CNT_W-1:0]    cfg_data,
  kvi_in_if.sink                            in_ch,
  kvi_out_if.source                         out_ch
);

  // key table: time and vector packed into one word, one read port
  kvi_pkg::kvi_key_t mem [kvi_pkg::MAX_KEYS];
  kvi_pkg::kvi_key_t rdata;
  logic [kvi_pkg::IDX_W-1:0] rd_addr;

  kvi_pkg::kvi_state_t state, state_next;

  logic [kvi_pkg::CNT_W-1:0]  key_count;
  logic [kvi_pkg::CNT_W-1:0]  n;
  logic [kvi_pkg::DATA_W-1:0] qt;
  logic [kvi_pkg::IDX_W-1:0]  idx;
  kvi_pkg::kvi_key_t          prev;
  logic [kvi_pkg::IDX_W-1:0]  seg;
  kvi_pkg::kvi_status_t       status;

  // per-lane start value, difference and product accumulator
  logic [kvi_pkg::DATA_W-1:0]        start [3];
  logic signed [kvi_pkg::DIFF_W-1:0] diff  [3];
  logic signed [kvi_pkg::ACC_W-1:0]  acc   [3];
  logic signed [kvi_pkg::ACC_W-1:0]  acc_next [3];

  // restoring divider, one quotient bit per cycle, msb first
  logic [kvi_pkg::DATA_W-1:0] rem, den, rem_next;
  logic [kvi_pkg::DIFF_W-1:0] rem_sh, rem_sub;
  logic                       qbit;
  logic [kvi_pkg::STEP_W-1:0] step;

  logic in_fire, sample_fire, load_out, found, zero_len, last_key;
  logic [kvi_pkg::CNT_W-1:0] n_clamp;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign sample_fire = in_fire && (in_ch.data.opcode == kvi_pkg::OP_SAMPLE);
  assign in_ch.ready = (state == kvi_pkg::S_IDLE);
  assign load_out    = (state == kvi_pkg::S_DONE) && (!out_ch.valid || out_ch.ready);

  // zero count acts as one, beyond the table acts as the full table
  always_comb begin
    n_clamp = key_count;
    if (key_count == '0) begin
      n_clamp = kvi_pkg::CNT_W'(1);
    end else if (key_count > kvi_pkg::CNT_W'(kvi_pkg::MAX_KEYS)) begin
      n_clamp = kvi_pkg::CNT_W'(kvi_pkg::MAX_KEYS);
    end
  end

  // scan decisions on the entry just read
  assign found    = qt < rdata.tick;
  assign zero_len = (rdata.tick <= prev.tick) || (qt < prev.tick);
  assign last_key = ({1'b0, idx} == (n - kvi_pkg::CNT_W'(1)));

  // address of the entry wanted on the next cycle
  always_comb begin
    case (state)
      kvi_pkg::S_FIRST: rd_addr = kvi_pkg::IDX_W'(1);
      kvi_pkg::S_SCAN:  rd_addr = idx + kvi_pkg::IDX_W'(1);
      default:          rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_ch.data.opcode == kvi_pkg::OP_WRITE)) begin
      mem[in_ch.data.key_index] <= '{tick: in_ch.data.sample_time, x: in_ch.data.in_x,
                                     y: in_ch.data.in_y, z: in_ch.data.in_z};
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    rem_sh   = {rem, 1'b0};
    rem_sub  = rem_sh - {1'b0, den};
    qbit     = (rem_sh >= {1'b0, den});
    rem_next = qbit ? rem_sub[kvi_pkg::DATA_W-1:0] : rem_sh[kvi_pkg::DATA_W-1:0];
    for (int l = 0; l < 3; l++) begin
      acc_next[l] = (acc[l] <<< 1) +
                    (qbit ? {{(kvi_pkg::ACC_W-kvi_pkg::DIFF_W){diff[l][kvi_pkg::DIFF_W-1]}},
                             diff[l]} : kvi_pkg::ACC_W'(0));
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kvi_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      kvi_pkg::S_IDLE: begin
        if (sample_fire) state_next = kvi_pkg::S_FIRST;
      end
      kvi_pkg::S_FIRST: begin
        if ((n == kvi_pkg::CNT_W'(1)) || found) state_next = kvi_pkg::S_DONE;
        else state_next = kvi_pkg::S_SCAN;
      end
      kvi_pkg::S_SCAN: begin
        if (found) begin
          state_next = zero_len ? kvi_pkg::S_DONE : kvi_pkg::S_INTERP;
        end else if (last_key) begin
          state_next = kvi_pkg::S_DONE;
        end
      end
      kvi_pkg::S_INTERP: begin
        if (step == kvi_pkg::STEP_W'(kvi_pkg::FRAC_BITS - 1)) state_next = kvi_pkg::S_DONE;
      end
      kvi_pkg::S_DONE: begin
        if (load_out) state_next = kvi_pkg::S_IDLE;
      end
      default: state_next = kvi_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= kvi_pkg::CNT_W'(1);
    end else if (cfg_write) begin
      key_count <= cfg_data;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      kvi_pkg::S_IDLE: begin
        if (sample_fire) begin
          qt <= in_ch.data.sample_time;
          n  <= n_clamp;
        end
      end
      kvi_pkg::S_FIRST: begin
        prev     <= rdata;
        idx      <= kvi_pkg::IDX_W'(1);
        seg      <= '0;
        start[0] <= rdata.x;
        start[1] <= rdata.y;
        start[2] <= rdata.z;
        for (int l = 0; l < 3; l++) acc[l] <= '0;
        status   <= ((n != kvi_pkg::CNT_W'(1)) && found) ? kvi_pkg::ST_BEFORE
                                                          : kvi_pkg::ST_OK;
      end
      kvi_pkg::S_SCAN: begin
        if (found) begin
          seg      <= idx - kvi_pkg::IDX_W'(1);
          start[0] <= prev.x;
          start[1] <= prev.y;
          start[2] <= prev.z;
          status   <= zero_len ? kvi_pkg::ST_ZERO_LEN : kvi_pkg::ST_OK;
          diff[0]  <= $signed({rdata.x[kvi_pkg::DATA_W-1], rdata.x})
                      - $signed({prev.x[kvi_pkg::DATA_W-1], prev.x});
          diff[1]  <= $signed({rdata.y[kvi_pkg::DATA_W-1], rdata.y})
                      - $signed({prev.y[kvi_pkg::DATA_W-1], prev.y});
          diff[2]  <= $signed({rdata.z[kvi_pkg::DATA_W-1], rdata.z})
                      - $signed({prev.z[kvi_pkg::DATA_W-1], prev.z});
          rem      <= qt - prev.tick;
          den      <= rdata.tick - prev.tick;
          step     <= '0;
        end else if (last_key) begin
          seg      <= kvi_pkg::IDX_W'(n - kvi_pkg::CNT_W'(2));
          start[0] <= rdata.x;
          start[1] <= rdata.y;
          start[2] <= rdata.z;
          status   <= kvi_pkg::ST_AFTER;
        end else begin
          prev <= rdata;
          idx  <= idx + kvi_pkg::IDX_W'(1);
        end
      end
      kvi_pkg::S_INTERP: begin
        rem  <= rem_next;
        step <= step + kvi_pkg::STEP_W'(1);
        for (int l = 0; l < 3; l++) acc[l] <= acc_next[l];
      end
      default: ;
    endcase
  end

  // output register, start plus floor(product / 2^frac)
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load_out) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.data.out_x   <= start[0] + acc[0][kvi_pkg::FRAC_BITS +: kvi_pkg::DATA_W];
      out_ch.data.out_y   <= start[1] + acc[1][kvi_pkg::FRAC_BITS +: kvi_pkg::DATA_W];
      out_ch.data.out_z   <= start[2] + acc[2][kvi_pkg::FRAC_BITS +: kvi_pkg::DATA_W];
      out_ch.data.segment <= seg;
      out_ch.data.status  <= status;
    end
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == kvi_pkg::S_INTERP) |-> (rem < den))
    else $error("divider remainder not below divisor");

  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    sample_fire |=> (state == kvi_pkg::S_FIRST))
    else $error("sample beat did not start a scan");

  a_before_seg0: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.data.status == kvi_pkg::ST_BEFORE)) |-> (out_ch.data.segment == '0))
    else $error("before-first-key result with non-zero segment");

endmodule
`default_nettype wire
